// ===== hw/rtl/ttcb_pkg.sv =====
package ttcb_pkg;

  // store geometry
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COLS_W   = $clog2(MAX_COLS + 1);
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
  localparam int CELL_AW  = ROW_AW + COL_AW;
  localparam int MEM_AW   = CELL_AW + 1;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(MAX_COLS);
  localparam logic [ROWS_W-1:0] ROWS_MAX = ROWS_W'(MAX_ROWS);
  localparam logic [7:0]        BLANK    = 8'h20;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // opcodes on the input channel
  localparam logic [2:0] OPC_WRITE   = 3'd0;
  localparam logic [2:0] OPC_NEWLINE = 3'd1;
  localparam logic [2:0] OPC_MOVE    = 3'd2;
  localparam logic [2:0] OPC_RESIZE  = 3'd3;
  localparam logic [2:0] OPC_READ    = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ROW    = 3'd1;
  localparam logic [2:0] ST_BAD_COL    = 3'd2;
  localparam logic [2:0] ST_BAD_BOTH   = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
  localparam logic [2:0] ST_READ_RANGE = 3'd5;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_NEWLINE,
    OP_MOVE,
    OP_RESIZE,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [7:0] row_arg;
    logic [7:0] col_arg;
    logic [7:0] size_cols;
    logic [7:0] size_rows;
  } in_t;

  typedef struct packed {
    logic [7:0] cell_byte;
    logic [5:0] cursor_row_out;
    logic [7:0] cursor_col_out;
    logic [2:0] status;
    logic       scrolled;
  } out_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [7:0] row_arg;
    logic [7:0] col_arg;
    logic [7:0] size_cols;
    logic [7:0] size_rows;
    logic       size_bad;
  } cmd_t;

endpackage

// ===== hw/rtl/ttcb_front.sv =====
module ttcb_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  ttcb_pkg::in_t   in_data,
  input  logic            q_full,
  input  logic            clearing,
  output logic            push,
  output ttcb_pkg::cmd_t  cmd
);

  // no transfer while the queue is full or the store is still being cleared
  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    cmd.char_code = in_data.char_code;
    cmd.row_arg   = in_data.row_arg;
    cmd.col_arg   = in_data.col_arg;
    cmd.size_cols = in_data.size_cols;
    cmd.size_rows = in_data.size_rows;
    // size check needs no state
    cmd.size_bad  = (in_data.size_cols == 8'd0) || (in_data.size_rows == 8'd0) ||
                    (in_data.size_cols > 8'(ttcb_pkg::COLS_MAX)) ||
                    (in_data.size_rows > 8'(ttcb_pkg::ROWS_MAX));
    unique case (in_data.opcode)
      ttcb_pkg::OPC_WRITE:   cmd.op = ttcb_pkg::OP_WRITE;
      ttcb_pkg::OPC_NEWLINE: cmd.op = ttcb_pkg::OP_NEWLINE;
      ttcb_pkg::OPC_MOVE:    cmd.op = ttcb_pkg::OP_MOVE;
      ttcb_pkg::OPC_RESIZE:  cmd.op = ttcb_pkg::OP_RESIZE;
      ttcb_pkg::OPC_READ:    cmd.op = ttcb_pkg::OP_READ;
      default:               cmd.op = ttcb_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/ttcb_queue.sv =====
module ttcb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ttcb_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ttcb_pkg::cmd_t  data
);

  ttcb_pkg::cmd_t                    slot_r [ttcb_pkg::QUEUE_DEPTH];
  logic [ttcb_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ttcb_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ttcb_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == ttcb_pkg::QCNT_W'(ttcb_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ttcb_pkg::QPTR_W'(ttcb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + ttcb_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ttcb_pkg::QPTR_W'(ttcb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + ttcb_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + ttcb_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - ttcb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/ttcb_back.sv =====
module ttcb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ttcb_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_stall,
  output ttcb_pkg::out_t  out_data
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_RESIZE = 6'b010000,
    S_RFIN   = 6'b100000
  } state_t;

  localparam int RW = ttcb_pkg::ROWS_W;
  localparam int CW = ttcb_pkg::COLS_W;
  localparam int RA = ttcb_pkg::ROW_AW;
  localparam int CA = ttcb_pkg::COL_AW;

  // physical row of a logical row, top and row both below rows
  function automatic logic [RA-1:0] phys_row(input logic [RA-1:0] top,
                                             input logic [RA-1:0] lrow,
                                             input logic [RW-1:0] rows);
    logic [RW-1:0] s;
    s = RW'(top) + RW'(lrow);
    if (s >= rows) begin
      s = s - rows;
    end
    return s[RA-1:0];
  endfunction

  function automatic ttcb_pkg::out_t mk_result(input logic [7:0]    cb,
                                               input logic [RA-1:0] row,
                                               input logic [CW-1:0] col,
                                               input logic [2:0]    st,
                                               input logic          sc);
    ttcb_pkg::out_t r;
    r.cell_byte      = cb;
    r.cursor_row_out = 6'(row);
    r.cursor_col_out = 8'(col);
    r.status         = st;
    r.scrolled       = sc;
    return r;
  endfunction

  // control state
  state_t                          state_r, state_nxt;
  logic                            bank_r, bank_nxt;
  logic [RA-1:0]                   top_r, top_nxt;
  logic [RA-1:0]                   cur_row_r, cur_row_nxt;
  logic [CW-1:0]                   cur_col_r, cur_col_nxt;
  logic [CW-1:0]                   act_cols_r, act_cols_nxt;
  logic [RW-1:0]                   act_rows_r, act_rows_nxt;
  logic [ttcb_pkg::CELL_AW-1:0]    cnt_r, cnt_nxt;
  logic                            rsz_pipe_r, rsz_pipe_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // payload state
  logic [RA-1:0]                   sc_row_r, sc_row_nxt;
  logic                            sc_char_r, sc_char_nxt;
  logic [7:0]                      ch_r, ch_nxt;
  logic [CW-1:0]                   new_cols_r, new_cols_nxt;
  logic [RW-1:0]                   new_rows_r, new_rows_nxt;
  logic [CW-1:0]                   keep_cols_r, keep_cols_nxt;
  logic [RW-1:0]                   keep_rows_r, keep_rows_nxt;
  logic [RA-1:0]                   src_row_r, src_row_nxt;
  logic                            rsz_keep_r, rsz_keep_nxt;
  logic [ttcb_pkg::MEM_AW-1:0]     rsz_waddr_r, rsz_waddr_nxt;
  ttcb_pkg::out_t                  out_data_r, out_data_nxt;

  // cell memory, two banks selected by the top address bit
  logic [7:0]                      mem_r [ttcb_pkg::MEM_DEPTH];
  logic [7:0]                      rdata_r;
  logic                            we;
  logic [ttcb_pkg::MEM_AW-1:0]     waddr, raddr;
  logic [7:0]                      wdata;

  logic                            start, imm;
  logic [2:0]                      res_st;
  logic                            need_nl, nl_scroll, bad_row, bad_col, rd_ok;
  logic [RW-1:0]                   row_inc, top_inc, rows_m1, src_inc, new_rows_m1;
  logic [RA-1:0]                   top_wrap, src_wrap, wr_lrow, wr_prow, rd_prow;
  logic [CA-1:0]                   wr_col;
  logic [RA-1:0]                   clamp_row;
  logic [CW-1:0]                   clamp_col;

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign start     = (state_r == S_IDLE) && q_valid && (!out_valid_r || !out_stall);

  assign need_nl   = (cur_col_r >= act_cols_r);
  assign row_inc   = RW'(cur_row_r) + RW'(1);
  assign nl_scroll = (row_inc >= act_rows_r);
  assign rows_m1   = act_rows_r - RW'(1);
  assign top_inc   = RW'(top_r) + RW'(1);
  assign top_wrap  = (top_inc == act_rows_r) ? '0 : top_inc[RA-1:0];
  assign src_inc   = RW'(src_row_r) + RW'(1);
  assign src_wrap  = (src_inc == act_rows_r) ? '0 : src_inc[RA-1:0];
  assign wr_lrow   = need_nl ? row_inc[RA-1:0] : cur_row_r;
  assign wr_col    = need_nl ? '0 : cur_col_r[CA-1:0];
  assign wr_prow   = phys_row(top_r, wr_lrow, act_rows_r);
  assign rd_prow   = phys_row(top_r, q_cmd.row_arg[RA-1:0], act_rows_r);
  assign bad_row   = (q_cmd.row_arg >= 8'(act_rows_r));
  assign bad_col   = (q_cmd.col_arg >= 8'(act_cols_r));
  assign rd_ok     = !bad_row && !bad_col;

  assign new_rows_m1 = new_rows_r - RW'(1);
  assign clamp_row   = (RW'(cur_row_r) >= new_rows_r) ? new_rows_m1[RA-1:0] : cur_row_r;
  assign clamp_col   = (cur_col_r >= new_cols_r) ? new_cols_r - CW'(1) : cur_col_r;

  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    top_nxt       = top_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    act_cols_nxt  = act_cols_r;
    act_rows_nxt  = act_rows_r;
    cnt_nxt       = cnt_r;
    rsz_pipe_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    sc_row_nxt    = sc_row_r;
    sc_char_nxt   = sc_char_r;
    ch_nxt        = ch_r;
    new_cols_nxt  = new_cols_r;
    new_rows_nxt  = new_rows_r;
    keep_cols_nxt = keep_cols_r;
    keep_rows_nxt = keep_rows_r;
    src_row_nxt   = src_row_r;
    rsz_keep_nxt  = rsz_keep_r;
    rsz_waddr_nxt = rsz_waddr_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    imm           = 1'b0;
    res_st        = ttcb_pkg::ST_OK;
    we            = 1'b0;
    waddr         = {bank_r, cnt_r};
    wdata         = ttcb_pkg::BLANK;
    raddr         = {bank_r, rd_prow, q_cmd.col_arg[CA-1:0]};

    // resize copy: the write follows in the cycle after its read
    if (rsz_pipe_r) begin
      we    = 1'b1;
      waddr = rsz_waddr_r;
      wdata = rsz_keep_r ? rdata_r : ttcb_pkg::BLANK;
    end

    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = {bank_r, cnt_r};
        wdata   = ttcb_pkg::BLANK;
        cnt_nxt = cnt_r + ttcb_pkg::CELL_AW'(1);
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          q_pop = 1'b1;
          imm   = 1'b1;
          unique case (q_cmd.op)
            ttcb_pkg::OP_WRITE: begin
              if (need_nl && nl_scroll) begin
                sc_row_nxt  = top_r;
                top_nxt     = top_wrap;
                cur_row_nxt = rows_m1[RA-1:0];
                cur_col_nxt = CW'(1);
                sc_char_nxt = 1'b1;
                ch_nxt      = q_cmd.char_code;
                cnt_nxt     = '0;
                state_nxt   = S_SCROLL;
                imm         = 1'b0;
              end else begin
                we          = 1'b1;
                waddr       = {bank_r, wr_prow, wr_col};
                wdata       = q_cmd.char_code;
                cur_row_nxt = wr_lrow;
                cur_col_nxt = need_nl ? CW'(1) : cur_col_r + CW'(1);
              end
            end
            ttcb_pkg::OP_NEWLINE: begin
              cur_col_nxt = '0;
              if (nl_scroll) begin
                sc_row_nxt  = top_r;
                top_nxt     = top_wrap;
                cur_row_nxt = rows_m1[RA-1:0];
                sc_char_nxt = 1'b0;
                cnt_nxt     = '0;
                state_nxt   = S_SCROLL;
                imm         = 1'b0;
              end else begin
                cur_row_nxt = row_inc[RA-1:0];
              end
            end
            ttcb_pkg::OP_MOVE: begin
              if (!bad_row) begin
                cur_row_nxt = q_cmd.row_arg[RA-1:0];
              end
              if (!bad_col) begin
                cur_col_nxt = q_cmd.col_arg;
              end
              priority if (bad_row && bad_col) begin
                res_st = ttcb_pkg::ST_BAD_BOTH;
              end else if (bad_row) begin
                res_st = ttcb_pkg::ST_BAD_ROW;
              end else if (bad_col) begin
                res_st = ttcb_pkg::ST_BAD_COL;
              end else begin
                res_st = ttcb_pkg::ST_OK;
              end
            end
            ttcb_pkg::OP_RESIZE: begin
              if (q_cmd.size_bad) begin
                res_st = ttcb_pkg::ST_BAD_SIZE;
              end else begin
                new_cols_nxt  = q_cmd.size_cols;
                new_rows_nxt  = q_cmd.size_rows[RW-1:0];
                keep_cols_nxt = (act_cols_r < q_cmd.size_cols) ? act_cols_r : q_cmd.size_cols;
                keep_rows_nxt = (act_rows_r < q_cmd.size_rows[RW-1:0]) ?
                                act_rows_r : q_cmd.size_rows[RW-1:0];
                src_row_nxt   = top_r;
                cnt_nxt       = '0;
                state_nxt     = S_RESIZE;
                imm           = 1'b0;
              end
            end
            ttcb_pkg::OP_READ: begin
              if (rd_ok) begin
                state_nxt = S_READ;
                imm       = 1'b0;
              end else begin
                res_st = ttcb_pkg::ST_READ_RANGE;
              end
            end
            default: begin
              res_st = ttcb_pkg::ST_OK;
            end
          endcase
          if (imm) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = mk_result(8'd0, cur_row_nxt, cur_col_nxt, res_st, 1'b0);
          end
        end
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = mk_result(rdata_r, cur_row_r, cur_col_r, ttcb_pkg::ST_OK, 1'b0);
        state_nxt     = S_IDLE;
      end

      S_SCROLL: begin
        we      = 1'b1;
        waddr   = {bank_r, sc_row_r, cnt_r[CA-1:0]};
        wdata   = (sc_char_r && (cnt_r[CA-1:0] == '0)) ? ch_r : ttcb_pkg::BLANK;
        cnt_nxt = cnt_r + ttcb_pkg::CELL_AW'(1);
        if (&cnt_r[CA-1:0]) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_result(8'd0, cur_row_r, cur_col_r, ttcb_pkg::ST_OK, 1'b1);
          state_nxt     = S_IDLE;
        end
      end

      S_RESIZE: begin
        raddr         = {bank_r, src_row_r, cnt_r[CA-1:0]};
        rsz_pipe_nxt  = 1'b1;
        rsz_keep_nxt  = (RW'(cnt_r[ttcb_pkg::CELL_AW-1:CA]) < keep_rows_r) &&
                        (CW'(cnt_r[CA-1:0]) < keep_cols_r);
        rsz_waddr_nxt = {~bank_r, cnt_r};
        cnt_nxt       = cnt_r + ttcb_pkg::CELL_AW'(1);
        if (&cnt_r[CA-1:0]) begin
          src_row_nxt = src_wrap;
        end
        if (&cnt_r) begin
          state_nxt = S_RFIN;
        end
      end

      S_RFIN: begin
        bank_nxt      = ~bank_r;
        top_nxt       = '0;
        act_cols_nxt  = new_cols_r;
        act_rows_nxt  = new_rows_r;
        cur_row_nxt   = clamp_row;
        cur_col_nxt   = clamp_col;
        out_valid_nxt = 1'b1;
        out_data_nxt  = mk_result(8'd0, clamp_row, clamp_col, ttcb_pkg::ST_OK, 1'b0);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      bank_r      <= 1'b0;
      top_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      act_cols_r  <= ttcb_pkg::COLS_MAX;
      act_rows_r  <= ttcb_pkg::ROWS_MAX;
      cnt_r       <= '0;
      rsz_pipe_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      top_r       <= top_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      act_cols_r  <= act_cols_nxt;
      act_rows_r  <= act_rows_nxt;
      cnt_r       <= cnt_nxt;
      rsz_pipe_r  <= rsz_pipe_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_row_r    <= sc_row_nxt;
    sc_char_r   <= sc_char_nxt;
    ch_r        <= ch_nxt;
    new_cols_r  <= new_cols_nxt;
    new_rows_r  <= new_rows_nxt;
    keep_cols_r <= keep_cols_nxt;
    keep_rows_r <= keep_rows_nxt;
    src_row_r   <= src_row_nxt;
    rsz_keep_r  <= rsz_keep_nxt;
    rsz_waddr_r <= rsz_waddr_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/text_terminal_cell_buffer_core.sv =====
// character-cell terminal store, 64 rows by 128 columns of bytes with a cursor; every
// accepted item gives exactly one result carrying the cursor after the operation, a
// status and a scrolled flag. after reset the block writes spaces into the store,
// one cell per cycle through the single memory write port, and holds in_stall high
// until that pass ends. a front decoder feeds a two-entry command queue, so up to
// two items can be taken while the back end is busy. write char and new line that
// do not scroll, move cursor, a rejected resize, a rejected read and unused opcodes
// finish without leaving the idle state of the back end, so a stream of them runs
// at one item per cycle while out_stall stays low; a read passes through the extra
// S_READ state because the memory read data is registered. a new line at the bottom
// row, or a write that wraps there, clears the new bottom row one cell per cycle.
// an accepted resize copies the whole store into the other memory bank cell by
// cell. the result sits in an output register, so the block keeps taking items into
// its queue while a result waits for out_stall to drop.
module text_terminal_cell_buffer_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ttcb_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ttcb_pkg::out_t  out_data
);

  // front to queue
  logic            push;
  ttcb_pkg::cmd_t  push_cmd;
  logic            q_full;

  // queue to back end
  logic            q_valid;
  logic            q_pop;
  ttcb_pkg::cmd_t  q_cmd;

  // back end still running its post-reset clearing pass
  logic            clearing;

  // decode and admit transfers
  ttcb_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  // decouples the front from long back-end operations
  ttcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_cmd)
  );

  // cursor, scroll pointer, cell memory and result register
  ttcb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command taken from empty queue");

  // an admitted transfer is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> q_valid)
    else $error("admitted transfer missing from queue");

  // no result can appear while the store is still being cleared
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid)
    else $error("result during clearing pass");

  // a rejected operation never scrolls
  a_err_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ttcb_pkg::ST_OK)) |-> !out_data.scrolled)
    else $error("rejected operation reported a scroll");
`endif

endmodule

// ===== sim/tb_text_terminal_cell_buffer_core.sv =====
`timescale 1ns / 100ps

module tb_text_terminal_cell_buffer_core;

  // opcodes the block treats as no-ops
  localparam logic [2:0] OPC_SPARE5 = 3'd5;
  localparam logic [2:0] OPC_SPARE6 = 3'd6;
  localparam logic [2:0] OPC_SPARE7 = 3'd7;

  // every accepted resize rewrites the whole store inside the block,
  // so the run caps how many of them get through
  localparam int RESIZE_BUDGET = 28;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int IN_W          = $bits(ttcb_pkg::in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ttcb_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ttcb_pkg::out_t out_data;

  text_terminal_cell_buffer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // stimulus and scoreboard storage
  ttcb_pkg::in_t  pending_cmds[$];
  ttcb_pkg::out_t expected_replies[$];
  int   total_items = 0;
  int   sent_count = 0;
  int   mismatches = 0;
  int   reply_count = 0;
  logic in_taken = 1'b0;

  // shadow copy of the terminal: cell store, scroll pointer, cursor, active area
  logic [7:0]                  screen  [ttcb_pkg::MAX_ROWS][ttcb_pkg::MAX_COLS];
  logic [7:0]                  scratch [ttcb_pkg::MAX_ROWS][ttcb_pkg::MAX_COLS];
  logic [ttcb_pkg::ROW_AW-1:0] top_row;
  logic [ttcb_pkg::ROWS_W-1:0] cur_row;
  logic [ttcb_pkg::ROWS_W-1:0] act_rows;
  logic [ttcb_pkg::COLS_W-1:0] cur_col;
  logic [ttcb_pkg::COLS_W-1:0] act_cols;

  // geometry as the stimulus generator sees it, tracked from accepted resizes
  int gen_cols = ttcb_pkg::MAX_COLS;
  int gen_rows = ttcb_pkg::MAX_ROWS;
  int resizes_left = RESIZE_BUDGET;

  // logical row to physical row through the circular top pointer
  function automatic int phys_row(input int logical);
    return (int'(top_row) + logical) % int'(act_rows);
  endfunction

  // new line: column 0 of the next row, scrolling at the bottom
  function automatic logic take_new_line();
    logic rolled;
    int   blank_row;
    rolled = 1'b0;
    cur_col = '0;
    cur_row = cur_row + ttcb_pkg::ROWS_W'(1);
    if (cur_row >= act_rows) begin
      // old top row becomes the fresh bottom row
      blank_row = phys_row(0);
      for (int c = 0; c < ttcb_pkg::MAX_COLS; c++) screen[blank_row][c] = ttcb_pkg::BLANK;
      top_row = ttcb_pkg::ROW_AW'((int'(top_row) + 1) % int'(act_rows));
      cur_row = act_rows - ttcb_pkg::ROWS_W'(1);
      rolled = 1'b1;
    end
    return rolled;
  endfunction

  // one command against the shadow terminal, giving the reply it must produce
  task automatic step_terminal(input ttcb_pkg::in_t cmd, output ttcb_pkg::out_t res);
    int keep_rows;
    int keep_cols;
    res = '0;
    case (cmd.opcode)
      ttcb_pkg::OPC_WRITE: begin
        // cursor past the last column wraps before the byte lands
        if (cur_col >= act_cols) res.scrolled = take_new_line();
        if (cur_col < ttcb_pkg::MAX_COLS)
          screen[phys_row(cur_row)][cur_col] = cmd.char_code;
        cur_col = cur_col + ttcb_pkg::COLS_W'(1);
      end
      ttcb_pkg::OPC_NEWLINE: res.scrolled = take_new_line();
      ttcb_pkg::OPC_MOVE: begin
        // row and column are judged on their own
        if (cmd.row_arg < act_rows) cur_row = ttcb_pkg::ROWS_W'(cmd.row_arg);
        else res.status = res.status | ttcb_pkg::ST_BAD_ROW;
        if (cmd.col_arg < act_cols) cur_col = cmd.col_arg;
        else res.status = res.status | ttcb_pkg::ST_BAD_COL;
      end
      ttcb_pkg::OPC_RESIZE: begin
        if (cmd.size_cols == 0 || cmd.size_rows == 0 ||
            cmd.size_cols > ttcb_pkg::MAX_COLS || cmd.size_rows > ttcb_pkg::MAX_ROWS) begin
          res.status = ttcb_pkg::ST_BAD_SIZE;
        end else begin
          keep_rows = (act_rows < cmd.size_rows) ? int'(act_rows) : int'(cmd.size_rows);
          keep_cols = (act_cols < cmd.size_cols) ? int'(act_cols) : int'(cmd.size_cols);
          // top-left overlap survives in logical order, everything else blank
          for (int r = 0; r < ttcb_pkg::MAX_ROWS; r++)
            for (int c = 0; c < ttcb_pkg::MAX_COLS; c++)
              scratch[r][c] = (r < keep_rows && c < keep_cols) ? screen[phys_row(r)][c]
                                                                : ttcb_pkg::BLANK;
          screen = scratch;
          top_row = '0;
          act_cols = cmd.size_cols;
          act_rows = ttcb_pkg::ROWS_W'(cmd.size_rows);
          if (cur_row >= cmd.size_rows) cur_row = ttcb_pkg::ROWS_W'(cmd.size_rows - 8'd1);
          if (cur_col >= cmd.size_cols) cur_col = cmd.size_cols - 8'd1;
        end
      end
      ttcb_pkg::OPC_READ: begin
        if (cmd.row_arg < act_rows && cmd.col_arg < act_cols &&
            cmd.col_arg < ttcb_pkg::MAX_COLS)
          res.cell_byte = screen[phys_row(cmd.row_arg)][cmd.col_arg];
        else
          res.status = ttcb_pkg::ST_READ_RANGE;
      end
      default: ;
    endcase
    res.cursor_row_out = cur_row[5:0];
    res.cursor_col_out = cur_col;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch on reply %0d, %s: got %0h, want %0h", reply_count, what, got, want);
  endtask

  // queue one command; resizes are counted against the budget here since
  // whether a size is accepted does not depend on the terminal state
  task automatic queue_cmd(input ttcb_pkg::in_t cmd);
    if (cmd.opcode == ttcb_pkg::OPC_RESIZE && cmd.size_cols != 0 && cmd.size_rows != 0 &&
        cmd.size_cols <= ttcb_pkg::MAX_COLS && cmd.size_rows <= ttcb_pkg::MAX_ROWS) begin
      if (resizes_left == 0) begin
        cmd.size_rows = '0;  // turn it into a rejected size
      end else begin
        resizes_left--;
        gen_cols = cmd.size_cols;
        gen_rows = cmd.size_rows;
      end
    end
    pending_cmds.push_back(cmd);
  endtask

  task automatic add_cmd(input logic [2:0] op, input logic [7:0] ch,
                         input logic [7:0] row, input logic [7:0] col,
                         input logic [7:0] scols, input logic [7:0] srows);
    ttcb_pkg::in_t cmd;
    cmd.opcode = op;
    cmd.char_code = ch;
    cmd.row_arg = row;
    cmd.col_arg = col;
    cmd.size_cols = scols;
    cmd.size_rows = srows;
    queue_cmd(cmd);
  endtask

  // driver: everything changes on the falling edge
  always @(negedge clk) begin : drive
    int send_gap;
    int recv_gap;
    // idle mix by thirds of the run: sender light / receiver heavy,
    // then swapped, then back to back with no idling at all
    if (sent_count < total_items / 3) begin
      send_gap = 20;
      recv_gap = 53;
    end else if (sent_count < 2 * total_items / 3) begin
      send_gap = 53;
      recv_gap = 20;
    end else begin
      send_gap = 0;
      recv_gap = 0;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      // a stalled transfer keeps its payload; otherwise offer the next one
      if (!in_valid || in_taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_gap) begin
          in_data <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_gap);
    end
  end

  // monitor: input transfers feed the shadow terminal, output transfers
  // are checked against the oldest expected reply
  always @(posedge clk) begin : watch
    ttcb_pkg::out_t want;
    ttcb_pkg::out_t got;
    if (rst_n && in_valid && !in_stall) begin
      step_terminal(in_data, want);
      expected_replies.push_back(want);
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no transfer pending", 32'(got), 32'h0);
      end else begin
        want = expected_replies.pop_front();
        if (got.cell_byte !== want.cell_byte)
          report_mismatch("cell_byte", 32'(got.cell_byte), 32'(want.cell_byte));
        if (got.cursor_row_out !== want.cursor_row_out)
          report_mismatch("cursor_row_out", 32'(got.cursor_row_out),
                          32'(want.cursor_row_out));
        if (got.cursor_col_out !== want.cursor_col_out)
          report_mismatch("cursor_col_out", 32'(got.cursor_col_out),
                          32'(want.cursor_col_out));
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.scrolled !== want.scrolled)
          report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
      end
      reply_count++;
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    ttcb_pkg::in_t cmd;
    int  pick;
    int  kind;

    // shadow terminal after reset
    for (int r = 0; r < ttcb_pkg::MAX_ROWS; r++)
      for (int c = 0; c < ttcb_pkg::MAX_COLS; c++) screen[r][c] = ttcb_pkg::BLANK;
    top_row = '0;
    cur_row = '0;
    cur_col = '0;
    act_cols = ttcb_pkg::COLS_MAX;
    act_rows = ttcb_pkg::ROWS_MAX;

    // directed: blank store, byte extremes, wrap and scroll at the bottom,
    // move flags, read range, rejected and accepted resizes, unused opcodes
    add_cmd(ttcb_pkg::OPC_READ,    8'h00, 8'd0,   8'd0,   8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_WRITE,   8'h00, 8'd0,   8'd0,   8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_WRITE,   8'hff, 8'd0,   8'd0,   8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_MOVE,    8'h00, 8'd63,  8'd127, 8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_WRITE,   "A",   8'd0,   8'd0,   8'd0,   8'd0);  // cursor lands on width
    add_cmd(ttcb_pkg::OPC_WRITE,   "B",   8'd0,   8'd0,   8'd0,   8'd0);  // wraps and scrolls
    add_cmd(ttcb_pkg::OPC_NEWLINE, 8'h00, 8'd0,   8'd0,   8'd0,   8'd0);  // scroll on bottom row
    add_cmd(ttcb_pkg::OPC_MOVE,    8'h00, 8'd64,  8'd128, 8'd0,   8'd0);  // both out of range
    add_cmd(ttcb_pkg::OPC_MOVE,    8'h00, 8'd255, 8'd0,   8'd0,   8'd0);  // row only
    add_cmd(ttcb_pkg::OPC_MOVE,    8'h00, 8'd0,   8'd255, 8'd0,   8'd0);  // column only
    add_cmd(ttcb_pkg::OPC_READ,    8'h00, 8'd64,  8'd0,   8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_READ,    8'h00, 8'd0,   8'd128, 8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_READ,    8'h00, 8'd62,  8'd0,   8'd0,   8'd0);  // wrapped byte moved up
    add_cmd(ttcb_pkg::OPC_RESIZE,  8'h00, 8'd0,   8'd0,   8'd0,   8'd64);
    add_cmd(ttcb_pkg::OPC_RESIZE,  8'h00, 8'd0,   8'd0,   8'd128, 8'd0);
    add_cmd(ttcb_pkg::OPC_RESIZE,  8'h00, 8'd0,   8'd0,   8'd129, 8'd64);
    add_cmd(ttcb_pkg::OPC_RESIZE,  8'h00, 8'd0,   8'd0,   8'd128, 8'd65);
    add_cmd(ttcb_pkg::OPC_RESIZE,  8'h00, 8'd0,   8'd0,   8'd2,   8'd2);  // clamps the cursor
    add_cmd(ttcb_pkg::OPC_WRITE,   "x",   8'd0,   8'd0,   8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_WRITE,   "y",   8'd0,   8'd0,   8'd0,   8'd0);
    add_cmd(ttcb_pkg::OPC_WRITE,   "w",   8'd0,   8'd0,   8'd0,   8'd0);  // wrap in a tiny area
    add_cmd(OPC_SPARE5,            8'hff, 8'd255, 8'd255, 8'd255, 8'd255);
    add_cmd(OPC_SPARE6,            8'h00, 8'd0,   8'd0,   8'd0,   8'd0);
    add_cmd(OPC_SPARE7,            8'h5a, 8'd1,   8'd1,   8'd1,   8'd1);
    add_cmd(ttcb_pkg::OPC_RESIZE,  8'h00, 8'd0,   8'd0,   8'd128, 8'd64);  // back to full size

    // random: mostly well-formed text traffic in the current area, small
    // areas so scrolling comes often, plus some fully random noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      cmd = ttcb_pkg::in_t'(IN_W'({$urandom, $urandom}));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cmd.opcode = ttcb_pkg::OPC_WRITE;
      end else if (pick < 60) begin
        cmd.opcode = ttcb_pkg::OPC_NEWLINE;
      end else if (pick < 70) begin
        cmd.opcode = ttcb_pkg::OPC_MOVE;
        if ($urandom_range(0, 4) != 0) begin
          cmd.row_arg = 8'($urandom_range(0, gen_rows - 1));
          cmd.col_arg = 8'($urandom_range(0, gen_cols - 1));
        end
      end else if (pick < 73) begin
        cmd.opcode = ttcb_pkg::OPC_RESIZE;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          cmd.size_cols = 8'($urandom_range(1, 12));
          cmd.size_rows = 8'($urandom_range(1, 6));
        end else if (kind == 6) begin
          cmd.size_cols = 8'($urandom_range(1, ttcb_pkg::MAX_COLS));
          cmd.size_rows = 8'($urandom_range(1, ttcb_pkg::MAX_ROWS));
        end else if (kind == 7) begin
          if ($urandom_range(0, 1)) cmd.size_cols = '0;
          else cmd.size_rows = '0;
        end else if (kind == 8) begin
          cmd.size_cols = 8'($urandom_range(ttcb_pkg::MAX_COLS + 1, 255));
        end else begin
          cmd.size_rows = 8'($urandom_range(ttcb_pkg::MAX_ROWS + 1, 255));
        end
      end else if (pick < 93) begin
        cmd.opcode = ttcb_pkg::OPC_READ;
        if ($urandom_range(0, 99) < 85) begin
          cmd.row_arg = 8'($urandom_range(0, gen_rows - 1));
          cmd.col_arg = 8'($urandom_range(0, gen_cols - 1));
        end
      end
      // the rest keeps all fields random, unused opcodes included
      queue_cmd(cmd);
    end
    total_items = pending_cmds.size();

    // synchronous reset, released on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every transfer offered, taken and answered
    while (reply_count < total_items)
      @(negedge clk);
    // quiet tail to catch stray replies
    repeat (300) @(negedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ttcb_pkg.sv
hw/rtl/ttcb_front.sv
hw/rtl/ttcb_queue.sv
hw/rtl/ttcb_back.sv
hw/rtl/text_terminal_cell_buffer_core.sv
sim/tb_text_terminal_cell_buffer_core.sv
